### sv/qrom_pkg.sv
`timescale 1ns / 1ps

package qrom_pkg;

    localparam int unsigned OP_W    = 1;
    localparam int unsigned QUEUE_W = 6;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned CHAN_W  = 12;
    localparam int unsigned ENTRY_W = CHAN_W + 1;
    // Wide enough for first_queue + queue_count and for table sizes up to 8191 entries.
    localparam int unsigned SUM_W   = 13;

    localparam logic [OP_W-1:0] OP_CLAIM = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_WRITE  = 6'b001000,
        S_FREE   = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

endpackage

### sv/queue_range_owner_map_top.sv
`timescale 1ns / 1ps

// A claim reads its range and writes it with its channel if no entry there is owned; a claim
// that fails on count or bounds goes straight to the result, one that hits an owned entry
// stops there. A free reads every entry and clears each one that its channel owns. One item
// is in work at a time; the single table memory is read every cycle and written in some.
// Reset starts a clearing pass that frees every entry; no item is accepted until it ends.
module queue_range_owner_map_top #(
    parameter int unsigned FUNCTIONS           = 8,
    parameter int unsigned QUEUES_PER_FUNCTION = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [qrom_pkg::OP_W-1:0]     i_opcode,
    input  logic [qrom_pkg::QUEUE_W-1:0]  i_first_queue,
    input  logic [qrom_pkg::COUNT_W-1:0]  i_queue_count,
    input  logic [qrom_pkg::CHAN_W-1:0]   i_channel_id,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_status
);
    import qrom_pkg::*;

    localparam int unsigned QUEUES = FUNCTIONS * QUEUES_PER_FUNCTION;
    localparam int unsigned QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int unsigned LW     = $clog2(QUEUES + 1);

    logic [ENTRY_W-1:0] r_mem [QUEUES];
    logic [ENTRY_W-1:0] r_rd_data;

    t_state              r_state,   n_state;
    logic [QW-1:0]       r_addr,    n_addr;
    logic [QW-1:0]       r_pa,      n_pa;
    logic [LW-1:0]       r_left,    n_left;
    logic [QW-1:0]       r_base,    n_base;
    logic [LW-1:0]       r_count,   n_count;
    logic [CHAN_W-1:0]   r_chan,    n_chan;
    logic                r_pv,      n_pv;
    logic                r_hit,     n_hit;
    logic                r_res,     n_res;
    logic                r_ovalid,  n_ovalid;
    logic                r_status,  n_status;

    logic                we;
    logic [QW-1:0]       wa;
    logic [ENTRY_W-1:0]  wd;
    logic                accept;
    logic                out_free;
    logic                match;
    logic [SUM_W-1:0]    range_end;

    assign accept    = i_valid && !o_stall;
    assign out_free  = !r_ovalid || !i_stall;
    assign match     = (r_rd_data == {1'b1, r_chan});
    assign range_end = SUM_W'(i_first_queue) + SUM_W'(i_queue_count);

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_status = r_status;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_pa     = r_pa;
        n_left   = r_left;
        n_base   = r_base;
        n_count  = r_count;
        n_chan   = r_chan;
        n_pv     = 1'b0;
        n_hit    = r_hit;
        n_res    = r_res;
        n_ovalid = r_ovalid && i_stall;
        n_status = r_status;
        we       = 1'b0;
        wa       = r_addr;
        wd       = '0;

        case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == QW'(QUEUES - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_chan = i_channel_id;
                    if (i_opcode == OP_FREE) begin
                        n_addr  = '0;
                        n_left  = LW'(QUEUES);
                        n_hit   = 1'b0;
                        n_state = S_FREE;
                    end else if (i_queue_count == '0 || range_end > SUM_W'(QUEUES)) begin
                        n_res   = STATUS_FAIL;
                        n_state = S_RESULT;
                    end else begin
                        n_addr  = QW'(i_first_queue);
                        n_base  = QW'(i_first_queue);
                        n_left  = LW'(i_queue_count);
                        n_count = LW'(i_queue_count);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // Reads go out one per cycle; each entry is checked when its data returns.
                if (r_left != '0) begin
                    n_addr = r_addr + 1'b1;
                    n_left = r_left - 1'b1;
                    n_pv   = 1'b1;
                end
                if (r_pv && r_rd_data[ENTRY_W-1]) begin
                    n_pv    = 1'b0;
                    n_res   = STATUS_FAIL;
                    n_state = S_RESULT;
                end else if (r_left == '0) begin
                    n_addr  = r_base;
                    n_left  = r_count;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                we     = 1'b1;
                wd     = {1'b1, r_chan};
                n_addr = r_addr + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == LW'(1)) begin
                    n_res   = STATUS_OK;
                    n_state = S_RESULT;
                end
            end
            S_FREE: begin
                // The entry read last cycle is cleared, if it matches the channel, while the next one is read.
                if (r_left != '0) begin
                    n_addr = r_addr + 1'b1;
                    n_left = r_left - 1'b1;
                    n_pa   = r_addr;
                    n_pv   = 1'b1;
                end
                if (r_pv && match) begin
                    we    = 1'b1;
                    wa    = r_pa;
                    n_hit = 1'b1;
                end
                if (r_left == '0) begin
                    n_pv    = 1'b0;
                    n_res   = (r_hit || (r_pv && match)) ? STATUS_OK : STATUS_FAIL;
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_left   <= '0;
            r_pv     <= 1'b0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_left   <= n_left;
            r_pv     <= n_pv;
            r_hit    <= n_hit;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa     <= n_pa;
        r_base   <= n_base;
        r_count  <= n_count;
        r_chan   <= n_chan;
        r_res    <= n_res;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_data <= r_mem[r_addr];
    end

endmodule
